// ----- hdl/assert_macros.svh -----
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) else $error(msg);

// An implication checked at every clock edge out of reset.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) else $error(msg);

// A condition whose consequence must hold in the next cycle.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/hbp_pkg.sv -----
// Package with widths, register indexes and reset values of the bbox projector.
package hbp_pkg;

    localparam int BOX_W      = 19;
    localparam int COEF_W     = 32;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int SIZE_W     = 13;

    localparam int DIM_BITS_DEF      = 12;
    localparam int BOX_FRAC_BITS_DEF = 16;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_H00_H01   = 3'd0,
        CFG_H02_H10   = 3'd1,
        CFG_H11_H12   = 3'd2,
        CFG_H20_H21   = 3'd3,
        CFG_H22       = 3'd4,
        CFG_SENSOR_W  = 3'd5,
        CFG_SENSOR_H  = 3'd6
    } cfg_idx_t;

    localparam logic [CFG_DATA_W-1:0] RST_H00_H01 = 64'h0010_0000_0000_0000;
    localparam logic [CFG_DATA_W-1:0] RST_H02_H10 = 64'h0;
    localparam logic [CFG_DATA_W-1:0] RST_H11_H12 = 64'h0010_0000_0000_0000;
    localparam logic [CFG_DATA_W-1:0] RST_H20_H21 = 64'h0;
    localparam logic [COEF_W-1:0]     RST_H22     = 32'h0010_0000;

endpackage

// ----- hdl/hbp_div.sv -----
// Pipelined restoring divider giving a saturated magnitude quotient and sign info.
module hbp_div #(
    parameter int NW = 52,
    parameter int QB = 13
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [NW-1:0] num,
    input  logic signed [NW-1:0] den,
    output logic [QB-1:0]        quo,
    output logic                 rem_nz,
    output logic                 neg,
    output logic                 den_zero
);
    localparam int CW = NW + QB;

    logic [NW-1:0] nmag0_reg;
    logic [NW-1:0] dmag0_reg;
    logic          neg0_reg;
    logic          dz0_reg;

    logic [NW-1:0] rem_reg [0:QB];
    logic [NW-1:0] dm_reg  [0:QB];
    logic [QB-1:0] q_reg   [0:QB];
    logic          neg_reg [0:QB];
    logic          dz_reg  [0:QB];
    logic          sat_reg [0:QB];

    // Magnitudes and the sign of the quotient.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nmag0_reg <= num[NW-1] ? NW'(-num) : NW'(num);
            dmag0_reg <= den[NW-1] ? NW'(-den) : NW'(den);
            neg0_reg  <= num[NW-1] ^ den[NW-1];
            dz0_reg   <= (den == '0);
        end
    end

    // Saturation check: the quotient does not fit in QB bits.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= nmag0_reg;
            dm_reg[0]  <= dmag0_reg;
            q_reg[0]   <= '0;
            neg_reg[0] <= neg0_reg;
            dz_reg[0]  <= dz0_reg;
            sat_reg[0] <= {{QB{1'b0}}, nmag0_reg} >= {dmag0_reg, {QB{1'b0}}};
        end
    end

    // One quotient bit per stage, most significant first.
    for (genvar s = 0; s < QB; s++)
    begin : g_step
        localparam int B = QB - 1 - s;
        logic [CW-1:0] dsh;
        logic          take;

        assign dsh  = {{QB{1'b0}}, dm_reg[s]} << B;
        assign take = {{QB{1'b0}}, rem_reg[s]} >= dsh;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s+1] <= take ? NW'({{QB{1'b0}}, rem_reg[s]} - dsh) : rem_reg[s];
                q_reg[s+1]   <= q_reg[s] | (take ? (QB'(1) << B) : '0);
                dm_reg[s+1]  <= dm_reg[s];
                neg_reg[s+1] <= neg_reg[s];
                dz_reg[s+1]  <= dz_reg[s];
                sat_reg[s+1] <= sat_reg[s];
            end
        end
    end

    assign quo      = sat_reg[QB] ? '1 : q_reg[QB];
    assign rem_nz   = sat_reg[QB] | (rem_reg[QB] != '0);
    assign neg      = neg_reg[QB];
    assign den_zero = dz_reg[QB];

endmodule

// ----- hdl/homography_bbox_projector.sv -----
// Top level of the homography bounding box projector.
//
//  channel | signals                                            | transfer when
//  in      | in_valid, in_ready, box_left/top/right/bottom      | in_valid & in_ready
//  out     | out_valid, out_ready, pixel_*, rect_valid          | out_valid & out_ready
//  cfg     | cfg_we, cfg_index, cfg_data                        | cfg_we
//
// One box enters per cycle unless the output stalls; the pipeline depth grows with
// DIM_BITS through the divider chain that resolves one quotient bit per stage.
// All four corners are projected in parallel lanes sharing twelve multipliers.
// Reset loads the configuration registers with their reset values and clears the stage valid bits.
// A stall at the output freezes every stage at once; nothing is lost or repeated.
module homography_bbox_projector
#(
    parameter int DIM_BITS      = hbp_pkg::DIM_BITS_DEF,
    parameter int BOX_FRAC_BITS = hbp_pkg::BOX_FRAC_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [hbp_pkg::BOX_W-1:0]       box_left,
    input  logic signed [hbp_pkg::BOX_W-1:0]       box_top,
    input  logic signed [hbp_pkg::BOX_W-1:0]       box_right,
    input  logic signed [hbp_pkg::BOX_W-1:0]       box_bottom,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [DIM_BITS-1:0]                    pixel_left,
    output logic [DIM_BITS-1:0]                    pixel_top,
    output logic [DIM_BITS-1:0]                    pixel_right,
    output logic [DIM_BITS-1:0]                    pixel_bottom,
    output logic                                   rect_valid,
    input  logic                                   cfg_we,
    input  logic [hbp_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [hbp_pkg::CFG_DATA_W-1:0]         cfg_data
);
    import hbp_pkg::*;

    `include "assert_macros.svh"

    localparam int XW   = BOX_FRAC_BITS + 1;
    localparam int PRW  = COEF_W + XW + 1;
    localparam int SW   = PRW + 2;
    localparam int QB   = DIM_BITS + 1;
    localparam int QW   = QB + 2;
    localparam int DL   = QB + 2;
    localparam int NST  = DL + 6;
    localparam int SZW  = (SIZE_W > DIM_BITS + 1) ? SIZE_W : DIM_BITS + 1;
    localparam logic [SZW-1:0] MAX_DIM = SZW'(1) << DIM_BITS;
    localparam logic signed [31:0] ONE_FX = 32'sd1 <<< BOX_FRAC_BITS;

    // Configuration registers.
    logic [CFG_DATA_W-1:0] h00_h01_reg, h02_h10_reg, h11_h12_reg, h20_h21_reg;
    logic [COEF_W-1:0]     h22_reg;
    logic [SIZE_W-1:0]     width_reg, height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h00_h01_reg <= RST_H00_H01;
            h02_h10_reg <= RST_H02_H10;
            h11_h12_reg <= RST_H11_H12;
            h20_h21_reg <= RST_H20_H21;
            h22_reg     <= RST_H22;
            width_reg   <= '0;
            height_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_H00_H01:  h00_h01_reg <= cfg_data;
                CFG_H02_H10:  h02_h10_reg <= cfg_data;
                CFG_H11_H12:  h11_h12_reg <= cfg_data;
                CFG_H20_H21:  h20_h21_reg <= cfg_data;
                CFG_H22:      h22_reg     <= cfg_data[COEF_W-1:0];
                CFG_SENSOR_W: width_reg   <= cfg_data[SIZE_W-1:0];
                CFG_SENSOR_H: height_reg  <= cfg_data[SIZE_W-1:0];
                default:      ;
            endcase
        end
    end

    logic signed [COEF_W-1:0] h0, h1, h2, h3, h4, h5, h6, h7, h8;
    assign h0 = h00_h01_reg[63:32];
    assign h1 = h00_h01_reg[31:0];
    assign h2 = h02_h10_reg[63:32];
    assign h3 = h02_h10_reg[31:0];
    assign h4 = h11_h12_reg[63:32];
    assign h5 = h11_h12_reg[31:0];
    assign h6 = h20_h21_reg[63:32];
    assign h7 = h20_h21_reg[31:0];
    assign h8 = h22_reg;

    // Global advance: the whole pipeline moves unless the output is held.
    logic en;
    logic [NST-1:0] vld_reg, vld_next;
    logic [NST-1:0] ok_reg;

    assign en       = !vld_reg[NST-1] || out_ready;
    assign in_ready = en;

    always_comb
    begin
        vld_next = {vld_reg[NST-2:0], in_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    // Stage 1: clamp the box to 0..1 and test for a degenerate box.
    function automatic logic [XW-1:0] clamp_box(input logic signed [BOX_W-1:0] raw);
        logic signed [31:0] v;
        v = 32'(raw);
        if (v < 0)
            return '0;
        else if (v > ONE_FX)
            return XW'(ONE_FX);
        else
            return v[XW-1:0];
    endfunction

    logic [XW-1:0] xa, xb, ya, yb;
    logic [XW-1:0] x_reg [0:1];
    logic [XW-1:0] y_reg [0:1];

    assign xa = clamp_box(box_left);
    assign xb = clamp_box(box_right);
    assign ya = clamp_box(box_top);
    assign yb = clamp_box(box_bottom);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= xa;
            x_reg[1] <= xb;
            y_reg[0] <= ya;
            y_reg[1] <= yb;
            ok_reg   <= {ok_reg[NST-2:0], (xb > xa) && (yb > ya)};
        end
    end

    // Stage 2: twelve products, one per coefficient and box edge.
    logic signed [PRW-1:0] p0_reg [0:1];
    logic signed [PRW-1:0] p3_reg [0:1];
    logic signed [PRW-1:0] p6_reg [0:1];
    logic signed [PRW-1:0] p1_reg [0:1];
    logic signed [PRW-1:0] p4_reg [0:1];
    logic signed [PRW-1:0] p7_reg [0:1];

    for (genvar a = 0; a < 2; a++)
    begin : g_mul
        logic signed [XW:0] xs, ys;
        assign xs = $signed({1'b0, x_reg[a]});
        assign ys = $signed({1'b0, y_reg[a]});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                p0_reg[a] <= PRW'(h0 * xs);
                p3_reg[a] <= PRW'(h3 * xs);
                p6_reg[a] <= PRW'(h6 * xs);
                p1_reg[a] <= PRW'(h1 * ys);
                p4_reg[a] <= PRW'(h4 * ys);
                p7_reg[a] <= PRW'(h7 * ys);
            end
        end
    end

    // Stage 3: numerators and denominator of each corner.
    logic signed [SW-1:0] c2, c5, c8;
    assign c2 = SW'(h2) <<< BOX_FRAC_BITS;
    assign c5 = SW'(h5) <<< BOX_FRAC_BITS;
    assign c8 = SW'(h8) <<< BOX_FRAC_BITS;

    logic [QB-1:0] q_x [0:3];
    logic [QB-1:0] q_y [0:3];
    logic          nz_x [0:3];
    logic          nz_y [0:3];
    logic          ng_x [0:3];
    logic          ng_y [0:3];
    logic          dz_x [0:3];
    logic          dz_y [0:3];

    logic signed [QW-1:0] fx_reg [0:3];
    logic signed [QW-1:0] cx_reg [0:3];
    logic signed [QW-1:0] fy_reg [0:3];
    logic signed [QW-1:0] cy_reg [0:3];

    // Floor and ceiling of a signed quotient from its magnitude parts.
    function automatic logic signed [QW-1:0] div_floor(
        input logic [QB-1:0] q, input logic nz, input logic ng, input logic dz);
        logic signed [QW-1:0] m;
        m = $signed({2'b00, q});
        if (dz)
            return '0;
        else if (ng)
            return -(m + QW'(nz));
        else
            return m;
    endfunction

    function automatic logic signed [QW-1:0] div_ceil(
        input logic [QB-1:0] q, input logic nz, input logic ng, input logic dz);
        logic signed [QW-1:0] m;
        m = $signed({2'b00, q});
        if (dz)
            return '0;
        else if (ng)
            return -m;
        else
            return m + QW'(nz);
    endfunction

    for (genvar k = 0; k < 4; k++)
    begin : g_corner
        // Corner order: (min,min) (max,min) (max,max) (min,max).
        localparam int XI = (k == 1 || k == 2) ? 1 : 0;
        localparam int YI = (k >= 2) ? 1 : 0;

        logic signed [SW-1:0] nx_reg, ny_reg, dn_reg;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                nx_reg <= SW'(p0_reg[XI]) + SW'(p1_reg[YI]) + c2;
                ny_reg <= SW'(p3_reg[XI]) + SW'(p4_reg[YI]) + c5;
                dn_reg <= SW'(p6_reg[XI]) + SW'(p7_reg[YI]) + c8;
            end
        end

        hbp_div #(.NW(SW), .QB(QB)) u_div_x (
            .clk      (clk),
            .en       (en),
            .num      (nx_reg),
            .den      (dn_reg),
            .quo      (q_x[k]),
            .rem_nz   (nz_x[k]),
            .neg      (ng_x[k]),
            .den_zero (dz_x[k])
        );

        hbp_div #(.NW(SW), .QB(QB)) u_div_y (
            .clk      (clk),
            .en       (en),
            .num      (ny_reg),
            .den      (dn_reg),
            .quo      (q_y[k]),
            .rem_nz   (nz_y[k]),
            .neg      (ng_y[k]),
            .den_zero (dz_y[k])
        );

        // Floor and ceiling stage.
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                fx_reg[k] <= div_floor(q_x[k], nz_x[k], ng_x[k], dz_x[k]);
                cx_reg[k] <= div_ceil(q_x[k], nz_x[k], ng_x[k], dz_x[k]);
                fy_reg[k] <= div_floor(q_y[k], nz_y[k], ng_y[k], dz_y[k]);
                cy_reg[k] <= div_ceil(q_y[k], nz_y[k], ng_y[k], dz_y[k]);
            end
        end
    end

    // Bounds of the four projected corners.
    logic signed [QW-1:0] fxmin, fxmax, cxmin, cxmax, fymin, fymax, cymin, cymax;
    logic signed [QW-1:0] fxmin_reg, fxmax_reg, cxmin_reg, cxmax_reg;
    logic signed [QW-1:0] fymin_reg, fymax_reg, cymin_reg, cymax_reg;

    always_comb
    begin
        fxmin = fx_reg[0];
        fxmax = fx_reg[0];
        cxmin = cx_reg[0];
        cxmax = cx_reg[0];
        fymin = fy_reg[0];
        fymax = fy_reg[0];
        cymin = cy_reg[0];
        cymax = cy_reg[0];
        for (int k = 1; k < 4; k++)
        begin
            if (fx_reg[k] < fxmin) fxmin = fx_reg[k];
            if (fx_reg[k] > fxmax) fxmax = fx_reg[k];
            if (cx_reg[k] < cxmin) cxmin = cx_reg[k];
            if (cx_reg[k] > cxmax) cxmax = cx_reg[k];
            if (fy_reg[k] < fymin) fymin = fy_reg[k];
            if (fy_reg[k] > fymax) fymax = fy_reg[k];
            if (cy_reg[k] < cymin) cymin = cy_reg[k];
            if (cy_reg[k] > cymax) cymax = cy_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fxmin_reg <= fxmin;
            fxmax_reg <= fxmax;
            cxmin_reg <= cxmin;
            cxmax_reg <= cxmax;
            fymin_reg <= fymin;
            fymax_reg <= fymax;
            cymin_reg <= cymin;
            cymax_reg <= cymax;
        end
    end

    // Sensor size limited to the largest supported dimension.
    logic [SZW-1:0]      w_ext, h_ext, w_c, h_c;
    logic [DIM_BITS-1:0] wm1, hm1;
    logic signed [QW-1:0] wm1_s, hm1_s;
    logic                cal_ok;

    assign w_ext  = SZW'(width_reg);
    assign h_ext  = SZW'(height_reg);
    assign w_c    = (w_ext > MAX_DIM) ? MAX_DIM : w_ext;
    assign h_c    = (h_ext > MAX_DIM) ? MAX_DIM : h_ext;
    assign wm1    = DIM_BITS'(w_c - SZW'(1));
    assign hm1    = DIM_BITS'(h_c - SZW'(1));
    assign wm1_s  = $signed({3'b000, wm1});
    assign hm1_s  = $signed({3'b000, hm1});
    assign cal_ok = (w_c != '0) && (h_c != '0);

    function automatic logic [DIM_BITS-1:0] clamp_pix(
        input logic signed [QW-1:0] v, input logic signed [QW-1:0] hi);
        if (v < 0)
            return '0;
        else if (v > hi)
            return hi[DIM_BITS-1:0];
        else
            return v[DIM_BITS-1:0];
    endfunction

    // Output stage: off-sensor rejection and clamping to the sensor.
    logic [DIM_BITS-1:0] x0, y0, x1, y1;
    logic                keep;
    logic [DIM_BITS-1:0] left_reg, top_reg, right_reg, bottom_reg;
    logic                rv_reg;

    assign x0   = clamp_pix(fxmin_reg, wm1_s);
    assign y0   = clamp_pix(fymin_reg, hm1_s);
    assign x1   = clamp_pix(cxmax_reg, wm1_s);
    assign y1   = clamp_pix(cymax_reg, hm1_s);
    assign keep = cal_ok && ok_reg[NST-2]
                  && !(fxmax_reg < 0) && !(fymax_reg < 0)
                  && !(cxmin_reg > wm1_s) && !(cymin_reg > hm1_s)
                  && (x1 >= x0) && (y1 >= y0);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            left_reg   <= keep ? x0 : '0;
            top_reg    <= keep ? y0 : '0;
            right_reg  <= keep ? x1 : '0;
            bottom_reg <= keep ? y1 : '0;
            rv_reg     <= keep;
        end
    end

    assign out_valid    = vld_reg[NST-1];
    assign pixel_left   = left_reg;
    assign pixel_top    = top_reg;
    assign pixel_right  = right_reg;
    assign pixel_bottom = bottom_reg;
    assign rect_valid   = rv_reg;

    // Checks on the result and on the stall behavior of the pipeline.
    `ASSERT_IMPLIES(a_invalid_zero, clk, rst_n, out_valid && !rect_valid,
        (pixel_left == '0) && (pixel_top == '0) && (pixel_right == '0) && (pixel_bottom == '0),
        "invalid result carries nonzero pixel fields")
    `ASSERT_IMPLIES(a_rect_order, clk, rst_n, out_valid && rect_valid,
        (pixel_left <= pixel_right) && (pixel_top <= pixel_bottom),
        "valid rectangle has inverted bounds")
    `ASSERT_IMPLIES(a_rect_on_sensor, clk, rst_n, out_valid && rect_valid,
        (pixel_right <= wm1) && (pixel_bottom <= hm1) && cal_ok,
        "valid rectangle lies outside the sensor")
    `ASSERT_NEXT(a_stall_holds, clk, rst_n, !en,
        vld_reg == $past(vld_reg),
        "pipeline occupancy changed during a stall")

endmodule
